[rtl/tep_pkg.sv]
// Shared types and constants for the tree entry stream parser.
package tep_pkg;

   localparam int MAX_ENTRIES = 128;
   localparam int HASH_BYTES  = 32;
   localparam int NAME_BYTES  = 256;
   localparam int MODE_LIMIT  = 16;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam int SLOTS = 3;

   typedef enum logic [4:0] {
      PH_MODE = 5'b00001,
      PH_NAME = 5'b00010,
      PH_HASH = 5'b00100,
      PH_FULL = 5'b01000,
      PH_ERR  = 5'b10000
   } phase_type;

   typedef enum logic [2:0] {
      K_NAME  = 3'd0,
      K_HASH  = 3'd1,
      K_ENTRY = 3'd2,
      K_OK    = 3'd3,
      K_ERR   = 3'd4
   } kind_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  byte_value;
      logic [31:0] entry_mode;
      logic [7:0]  entry_number;
      logic [7:0]  field_offset;
      logic        last_result;
   } result_type;

   typedef struct packed {
      result_type [SLOTS-1:0] slot;
      logic [1:0]             count;
   } bundle_type;

endpackage

[rtl/tep_if.sv]
// Valid/ready channel interfaces for the parser's input bytes and results.
interface tep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface tep_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  byte_value;
   logic [31:0] entry_mode;
   logic [7:0]  entry_number;
   logic [7:0]  field_offset;
   logic        last_result;

   modport source (output valid, output kind, output byte_value, output entry_mode,
                   output entry_number, output field_offset, output last_result,
                   input ready);
   modport sink (input valid, input kind, input byte_value, input entry_mode,
                 input entry_number, input field_offset, input last_result,
                 output ready);
endinterface

[rtl/tep_parse.sv]
// Parse state and per-byte decode into a bundle of up to three results.
module tep_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 end_of_buffer,
   output tep_pkg::bundle_type  bundle
);

   tep_pkg::phase_type phase_ff, phase_in;
   logic [31:0]        acc_ff, acc_in;
   logic               stop_ff, stop_in;
   logic [7:0]         len_ff, len_in;
   logic [7:0]         done_ff, done_in;

   logic [8:0] len_plus;
   logic [8:0] done_plus;
   logic       is_digit;
   logic       ok;
   logic [1:0] n;

   assign len_plus  = {1'b0, len_ff} + 9'd1;
   assign done_plus = {1'b0, done_ff} + 9'd1;
   assign is_digit  = (data_byte[7:3] == 5'b00110);

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      stop_in  = stop_ff;
      len_in   = len_ff;
      done_in  = done_ff;
      bundle   = '0;
      n        = 2'd0;
      ok       = 1'b0;

      case (phase_ff)
         tep_pkg::PH_MODE: begin
            if (data_byte == tep_pkg::CHAR_SPACE) begin
               phase_in = tep_pkg::PH_NAME;
               len_in   = 8'd0;
            end else if (len_plus >= 9'(tep_pkg::MODE_LIMIT)) begin
               phase_in = tep_pkg::PH_ERR;
            end else begin
               if (!stop_ff && is_digit) begin
                  acc_in = {acc_ff[28:0], data_byte[2:0]};
               end else begin
                  stop_in = 1'b1;
               end
               len_in = len_plus[7:0];
            end
         end
         tep_pkg::PH_NAME: begin
            if (data_byte == tep_pkg::CHAR_NUL) begin
               phase_in = tep_pkg::PH_HASH;
               len_in   = 8'd0;
            end else if (len_plus >= 9'(tep_pkg::NAME_BYTES)) begin
               phase_in = tep_pkg::PH_ERR;
            end else begin
               bundle.slot[0].kind         = tep_pkg::K_NAME;
               bundle.slot[0].byte_value   = data_byte;
               bundle.slot[0].entry_number = done_ff;
               bundle.slot[0].field_offset = len_ff;
               n      = 2'd1;
               len_in = len_plus[7:0];
            end
         end
         tep_pkg::PH_HASH: begin
            bundle.slot[0].kind         = tep_pkg::K_HASH;
            bundle.slot[0].byte_value   = data_byte;
            bundle.slot[0].entry_number = done_ff;
            bundle.slot[0].field_offset = len_ff;
            n      = 2'd1;
            len_in = len_plus[7:0];
            if (len_plus >= 9'(tep_pkg::HASH_BYTES)) begin
               bundle.slot[1].kind         = tep_pkg::K_ENTRY;
               bundle.slot[1].entry_mode   = acc_ff;
               bundle.slot[1].entry_number = done_ff;
               n       = 2'd2;
               done_in = done_plus[7:0];
               acc_in  = 32'd0;
               stop_in = 1'b0;
               len_in  = 8'd0;
               phase_in = (done_plus >= 9'(tep_pkg::MAX_ENTRIES)) ? tep_pkg::PH_FULL
                                                                   : tep_pkg::PH_MODE;
            end
         end
         default: begin
         end
      endcase

      if (end_of_buffer) begin
         ok = (phase_in == tep_pkg::PH_FULL) ||
              ((phase_in == tep_pkg::PH_MODE) && (len_in == 8'd0));
         bundle.slot[n].kind         = ok ? tep_pkg::K_OK : tep_pkg::K_ERR;
         bundle.slot[n].entry_number = done_in;
         n        = n + 2'd1;
         phase_in = tep_pkg::PH_MODE;
         acc_in   = 32'd0;
         stop_in  = 1'b0;
         len_in   = 8'd0;
         done_in  = 8'd0;
      end

      if (n != 2'd0) begin
         bundle.slot[n - 2'd1].last_result = 1'b1;
      end
      bundle.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tep_pkg::PH_MODE;
         acc_ff   <= 32'd0;
         stop_ff  <= 1'b0;
         len_ff   <= 8'd0;
         done_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         stop_ff  <= stop_in;
         len_ff   <= len_in;
         done_ff  <= done_in;
      end
   end

endmodule

[rtl/tep_drain.sv]
// Result register for one bundle; one result leaves per cycle while rsp_ready.
module tep_drain (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  tep_pkg::bundle_type  load_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output tep_pkg::result_type  rsp_data,
   output logic                 free
);

   tep_pkg::bundle_type bundle_ff, bundle_in;
   logic [1:0]          idx_ff, idx_in;
   logic                valid_ff, valid_in;

   assign rsp_data  = bundle_ff.slot[idx_ff];
   assign rsp_valid = valid_ff;
   assign free      = !valid_ff || (rsp_ready && rsp_data.last_result);

   always_comb begin
      bundle_in = bundle_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      if (valid_ff && rsp_ready && !rsp_data.last_result) begin
         idx_in = idx_ff + 2'd1;
      end
      if (free) begin
         valid_in = load;
         idx_in   = 2'd0;
         if (load) begin
            bundle_in = load_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bundle_ff <= bundle_in;
   end

endmodule

[rtl/tree_entry_stream_parser_core.sv]
// Top level of the tree entry stream parser.
//
//  channel  | dir | handshake          | payload
//  req_ch   | in  | valid/ready        | data_byte, end_of_buffer
//  rsp_ch   | out | valid/ready        | kind, byte_value, entry_mode, entry_number,
//           |     |                    | field_offset, last_result
//
// A byte is decoded in the cycle it is taken; its results (one to three, or none)
// land in the result register the next cycle and leave one per cycle while rsp_ch
// is ready. One byte per cycle while each byte yields at most one result and rsp_ch
// is ready; otherwise req_ch.ready stays low until the byte's last result is taken.
// Reset returns the parser to the start of a buffer and empties the result register.
// rsp_ch stalls hold the current result and back-pressure req_ch.
module tree_entry_stream_parser_core (
   input logic       clock,
   input logic       reset,
   tep_req_if.sink   req_ch,
   tep_rsp_if.source rsp_ch
);

   tep_pkg::bundle_type bundle;
   tep_pkg::result_type rsp_data;
   logic                free;
   logic                accept;

   assign req_ch.ready = free;
   assign accept       = req_ch.valid && free;

   tep_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_ch.data_byte),
      .end_of_buffer (req_ch.end_of_buffer),
      .bundle        (bundle)
   );

   tep_drain u_drain (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && (bundle.count != 2'd0)),
      .load_data (bundle),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_data  (rsp_data),
      .free      (free)
   );

   assign rsp_ch.kind         = rsp_data.kind;
   assign rsp_ch.byte_value   = rsp_data.byte_value;
   assign rsp_ch.entry_mode   = rsp_data.entry_mode;
   assign rsp_ch.entry_number = rsp_data.entry_number;
   assign rsp_ch.field_offset = rsp_data.field_offset;
   assign rsp_ch.last_result  = rsp_data.last_result;

endmodule
